FILE: design/bhc_pkg.sv
// bhc_pkg: shared widths, event codes and debounce constants
// for the button hold confirm block; no dependencies
`default_nettype none

package bhc_pkg;

  localparam int TIME_W   = 16;
  localparam int EVENT_W  = 2;
  localparam int BUDGET_W = 17;
  localparam int LEVEL_W  = 2;
  localparam int RUN_W    = 3;

  // event codes carried in event_res
  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_REQUEST = 2'd1;
  localparam logic [EVENT_W-1:0] EV_SUCCESS = 2'd2;
  localparam logic [EVENT_W-1:0] EV_FAILURE = 2'd3;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // debouncer run levels
  localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_UP   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DOWN = 2'd2;

  localparam logic [RUN_W-1:0] RUN_NEEDED = 3'd4;
  localparam logic [RUN_W-1:0] RUN_MAX    = 3'd7;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX = {BUDGET_W{1'b1}};

  localparam logic [TIME_W-1:0] TIMEOUT_EXTRA_RESET = 16'd60;

endpackage

`default_nettype wire

FILE: design/bhc_if.sv
// bhc_if: valid/ready channel interfaces for the request, result and
// configuration words; depends on bhc_pkg
`default_nettype none

interface bhc_req_if import bhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              pin_level;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] hold_target;

  modport source (output valid, output cmd, output pin_level, output base_time,
                  output hold_target, input ready);
  modport sink   (input valid, input cmd, input pin_level, input base_time,
                  input hold_target, output ready);
endinterface

interface bhc_res_if import bhc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic               led_on;
  logic               busy_res;

  modport source (output valid, output event_res, output led_on, output busy_res,
                  input ready);
  modport sink   (input valid, input event_res, input led_on, input busy_res,
                  output ready);
endinterface

interface bhc_cfg_if import bhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/button_hold_confirm.sv
// button_hold_confirm: debounced long press detector with timeout budget
// depends on bhc_pkg and the channel interfaces in bhc_if
//
//   channel  dir  word                                         handshake
//   req_ch   in   cmd, pin_level, base_time, hold_target       valid/ready
//   res_ch   out  event_res, led_on, busy_res                  valid/ready
//   cfg_ch   in   data (timeout_extra)                         valid/ready
//
// one request word in, one result word out
// the whole update is combinational from the request word into the
// result register; a new word is taken each cycle the result register
// is empty or being drained in that same cycle
// a stalled result holds and blocks new request words until taken
// rst is synchronous, active high; clears control state and sets
// timeout_extra back to 60
`default_nettype none

module button_hold_confirm import bhc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire      clk,
  input  wire      rst,
  bhc_req_if.sink  req_ch,
  bhc_res_if.source res_ch,
  bhc_cfg_if.sink  cfg_ch
);

  // common compare width for the hold counter against the target
  localparam int CMP_W = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;
  localparam logic [COUNT_BITS-1:0] HOLD_MAX = {COUNT_BITS{1'b1}};

  // configuration
  logic [TIME_W-1:0] timeout_extra;

  // confirmation state
  logic                  active;
  logic [LEVEL_W-1:0]    run_level;
  logic [RUN_W-1:0]      run_count;
  logic                  seen_release;
  logic [COUNT_BITS-1:0] hold_count;
  logic [TIME_W-1:0]     target;
  logic [BUDGET_W-1:0]   budget;
  logic                  led_level;

  logic                  active_next;
  logic [LEVEL_W-1:0]    run_level_next;
  logic [RUN_W-1:0]      run_count_next;
  logic                  seen_release_next;
  logic [COUNT_BITS-1:0] hold_count_next;
  logic [TIME_W-1:0]     target_next;
  logic [BUDGET_W-1:0]   budget_next;
  logic                  led_level_next;
  logic [EVENT_W-1:0]    event_next;

  // result register
  logic               res_valid;
  logic [EVENT_W-1:0] res_event;
  logic               res_led;
  logic               res_busy;

  logic req_take;

  assign req_ch.ready = !res_valid || res_ch.ready;
  assign req_take     = req_ch.valid && req_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign res_ch.valid     = res_valid;
  assign res_ch.event_res = res_event;
  assign res_ch.led_on    = res_led;
  assign res_ch.busy_res  = res_busy;

  // per-word update
  always_comb begin
    logic [LEVEL_W-1:0]    lvl;
    logic                  down;
    logic [BUDGET_W-1:0]   spent;
    logic [COUNT_BITS-1:0] hc;
    logic [BUDGET_W-1:0]   start_budget;

    active_next       = active;
    run_level_next    = run_level;
    run_count_next    = run_count;
    seen_release_next = seen_release;
    hold_count_next   = hold_count;
    target_next       = target;
    budget_next       = budget;
    led_level_next    = led_level;
    event_next        = EV_NONE;

    lvl          = req_ch.pin_level ? LVL_UP : LVL_DOWN;
    down         = !req_ch.pin_level;
    spent        = (budget != '0) ? budget - 1'b1 : '0;
    hc           = hold_count;
    // two 16-bit values always fit in the 17-bit budget
    start_budget = {1'b0, req_ch.base_time} + {1'b0, timeout_extra};

    if (req_ch.cmd == CMD_START) begin
      if (!active) begin
        if (req_ch.base_time == '0) begin
          event_next = EV_SUCCESS;
        end else begin
          active_next       = 1'b1;
          run_level_next    = LVL_NONE;
          run_count_next    = '0;
          seen_release_next = 1'b0;
          hold_count_next   = '0;
          target_next       = req_ch.hold_target;
          budget_next       = start_budget;
          event_next        = EV_REQUEST;
        end
      end
    end else if (active) begin
      // debounce: count equal samples in a row
      if (lvl == run_level) begin
        if (run_count < RUN_MAX) run_count_next = run_count + 1'b1;
      end else begin
        run_level_next = lvl;
        run_count_next = 3'd1;
      end

      if (run_count_next >= RUN_NEEDED) begin
        run_level_next = LVL_NONE;
        run_count_next = '0;
        // decision: toggle led, spend one unit
        led_level_next = !led_level;
        budget_next    = spent;
        if (spent == '0) begin
          event_next = EV_FAILURE;
        end else if (!seen_release && down) begin
          // press held over from before the start is ignored
          event_next = EV_NONE;
        end else begin
          if (!seen_release) begin
            seen_release_next = 1'b1;
            hc                = '0;
          end
          if (hc != '0 && !down) begin
            event_next = EV_FAILURE;
          end else begin
            if (down) begin
              if (hc < HOLD_MAX) hc = hc + 1'b1;
              // spent is below the max, so the refund cannot wrap
              budget_next = spent + 1'b1;
            end
            hold_count_next = hc;
            if (CMP_W'(hc) >= CMP_W'(target)) event_next = EV_SUCCESS;
          end
        end
        if (event_next != EV_NONE) begin
          active_next    = 1'b0;
          led_level_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_extra <= TIMEOUT_EXTRA_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      timeout_extra <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      run_level    <= LVL_NONE;
      run_count    <= '0;
      seen_release <= 1'b0;
      hold_count   <= '0;
      target       <= '0;
      budget       <= '0;
      led_level    <= 1'b0;
    end else if (req_take) begin
      active       <= active_next;
      run_level    <= run_level_next;
      run_count    <= run_count_next;
      seen_release <= seen_release_next;
      hold_count   <= hold_count_next;
      target       <= target_next;
      budget       <= budget_next;
      led_level    <= led_level_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_take) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_take) begin
      res_event <= event_next;
      res_led   <= led_level_next;
      res_busy  <= active_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/bhc_checker.sv
// bhc_checker: port-level assertions for button_hold_confirm and its bind
// depends on bhc_pkg
`default_nettype none

module bhc_checker import bhc_pkg::*; (
  input wire               clk,
  input wire               rst,
  input wire               res_valid,
  input wire               res_ready,
  input wire [EVENT_W-1:0] event_res,
  input wire               led_on,
  input wire               busy_res
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res) &&
      $stable(led_on) && $stable(busy_res))
    else $error("result word changed while stalled");

  // idle block always shows the led off
  a_idle_led_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && !busy_res |-> !led_on)
    else $error("led on while not busy");

  // a request leaves the block busy
  a_request_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == EV_REQUEST |-> busy_res)
    else $error("request without busy");

  // success or failure ends the confirmation
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_SUCCESS || event_res == EV_FAILURE) |-> !busy_res)
    else $error("busy after end of confirmation");

endmodule

bind button_hold_confirm bhc_checker u_bhc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_ch.valid),
  .res_ready (res_ch.ready),
  .event_res (res_ch.event_res),
  .led_on    (res_ch.led_on),
  .busy_res  (res_ch.busy_res)
);

`default_nettype wire

FILE: sim/tb_button_hold_confirm.sv
// tb_button_hold_confirm: self-checking bench for the button hold confirm block,
// directed and random request words checked against an in-bench predictor
// depends on bhc_pkg, the channel interfaces in bhc_if and button_hold_confirm
`timescale 1ns / 100ps

module tb_button_hold_confirm;
  import bhc_pkg::*;

  localparam int HOLD_W = 16;                 // matches COUNT_BITS of the instance
  localparam longint RUN_LIMIT_NS = 30_000_000;

  // one request word and one result word as the bench sees them
  typedef struct packed {
    logic              cmd;
    logic              pin;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] goal;
  } hold_req_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic               led_on;
    logic               busy_res;
  } hold_res_t;

  logic clk;
  logic rst;

  bhc_req_if req_ch ();
  bhc_res_if res_ch ();
  bhc_cfg_if cfg_ch ();

  button_hold_confirm #(.COUNT_BITS(HOLD_W)) DUT (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // words waiting to be sent, and results owed by the block, oldest first
  hold_req_t pending_req[$];
  hold_res_t expected_res[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_cfg      = 0;
  int n_request  = 0;
  int n_success  = 0;
  int n_failure  = 0;

  // predictor copy of the block state and of timeout_extra
  logic [TIME_W-1:0]   extra_q    = TIMEOUT_EXTRA_RESET;
  logic                active_q   = 1'b0;
  logic [LEVEL_W-1:0]  run_lvl_q  = LVL_NONE;
  logic [RUN_W-1:0]    run_cnt_q  = '0;
  logic                seen_rel_q = 1'b0;
  logic [HOLD_W-1:0]   hold_q     = '0;
  logic [TIME_W-1:0]   goal_q     = '0;
  logic [BUDGET_W-1:0] budget_q   = '0;
  logic                led_q      = 1'b0;

  // confirmation over: block goes idle with the led dark
  function automatic logic [EVENT_W-1:0] end_confirm(input logic [EVENT_W-1:0] ev);
    active_q = 1'b0;
    led_q    = 1'b0;
    return ev;
  endfunction

  // one debounced decision: toggle, spend, then the hold rules
  function automatic logic [EVENT_W-1:0] apply_decision(input logic down);
    led_q = ~led_q;
    if (budget_q != '0) budget_q--;
    if (budget_q == '0) return end_confirm(EV_FAILURE);
    if (!seen_rel_q) begin
      // a press still held over from before the request does not count
      if (down) return EV_NONE;
      seen_rel_q = 1'b1;
      hold_q     = '0;
    end
    // let go after holding for a while
    if (hold_q != '0 && !down) return end_confirm(EV_FAILURE);
    if (down) begin
      if (hold_q != '1) hold_q++;
      // a down decision gives back the unit it spent
      if (budget_q != BUDGET_MAX) budget_q++;
    end
    if (hold_q >= goal_q) return end_confirm(EV_SUCCESS);
    return EV_NONE;
  endfunction

  // expected result word for one accepted request word; updates the state copy
  function automatic hold_res_t predict_result(input hold_req_t w);
    hold_res_t           r;
    logic [LEVEL_W-1:0]  lvl;
    logic [BUDGET_W:0]   sum;
    r.event_res = EV_NONE;
    if (w.cmd == CMD_START) begin
      // a start while busy is dropped without a trace
      if (!active_q) begin
        if (w.base == '0) begin
          r.event_res = EV_SUCCESS;
        end else begin
          active_q   = 1'b1;
          run_lvl_q  = LVL_NONE;
          run_cnt_q  = '0;
          seen_rel_q = 1'b0;
          hold_q     = '0;
          goal_q     = w.goal;
          sum        = {2'b00, w.base} + {2'b00, extra_q};
          budget_q   = (sum > BUDGET_MAX) ? BUDGET_MAX : sum[BUDGET_W-1:0];
          r.event_res = EV_REQUEST;
        end
      end
    end else if (active_q) begin
      // debouncer: four equal samples in a row make one decision
      lvl = w.pin ? LVL_UP : LVL_DOWN;
      if (lvl == run_lvl_q) begin
        if (run_cnt_q < RUN_MAX) run_cnt_q++;
      end else begin
        run_lvl_q = lvl;
        run_cnt_q = RUN_W'(1);
      end
      if (run_cnt_q >= RUN_NEEDED) begin
        run_lvl_q   = LVL_NONE;
        run_cnt_q   = '0;
        r.event_res = apply_decision(lvl == LVL_DOWN);
      end
    end
    r.led_on   = led_q;
    r.busy_res = active_q;
    return r;
  endfunction

  // gap length: mostly none, some short, a few long; none at all in calm stretches
  function automatic int unsigned idle_cycles(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: takes words from pending_req, predicts on each accepted word
  // ---------------------------------------------------------------------------
  int unsigned feed_gap  = 0;
  bit          feed_calm = 1'b0;

  always @(posedge clk) begin : feed_blk
    hold_req_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
      feed_gap     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        w = '{req_ch.cmd, req_ch.pin_level, req_ch.base_time, req_ch.hold_target};
        expected_res.push_back(predict_result(w));
        n_accepted++;
      end
      // the bus is free once the current word has gone or none is up
      if (!req_ch.valid || req_ch.ready) begin
        if (feed_gap != 0) begin
          feed_gap     <= feed_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          w = pending_req.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.cmd         <= w.cmd;
          req_ch.pin_level   <= w.pin;
          req_ch.base_time   <= w.base;
          req_ch.hold_target <= w.goal;
          if ($urandom_range(0, 99) == 0) feed_calm <= ~feed_calm;
          // gap applies after this word is taken
          feed_gap <= idle_cycles(feed_calm);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random back-pressure, field compare against oldest expected
  // ---------------------------------------------------------------------------
  int unsigned drain_gap  = 0;
  bit          drain_calm = 1'b0;

  always @(posedge clk) begin : drain_blk
    hold_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      drain_gap    <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        case (res_ch.event_res)
          EV_REQUEST: n_request++;
          EV_SUCCESS: n_success++;
          EV_FAILURE: n_failure++;
          default: ;
        endcase
        if (expected_res.size() == 0) begin
          $error("result word with nothing expected: event_res %0d led_on %0d busy_res %0d",
                 res_ch.event_res, res_ch.led_on, res_ch.busy_res);
          n_errors++;
        end else begin
          want = expected_res.pop_front();
          if (res_ch.event_res !== want.event_res) begin
            $error("event_res expected %0d actual %0d", want.event_res, res_ch.event_res);
            n_errors++;
          end
          if (res_ch.led_on !== want.led_on) begin
            $error("led_on expected %0d actual %0d", want.led_on, res_ch.led_on);
            n_errors++;
          end
          if (res_ch.busy_res !== want.busy_res) begin
            $error("busy_res expected %0d actual %0d", want.busy_res, res_ch.busy_res);
            n_errors++;
          end
        end
      end
      if (drain_gap != 0) begin
        drain_gap    <= drain_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) drain_gap <= idle_cycles(drain_calm);
      end
      if ($urandom_range(0, 199) == 0) drain_calm <= ~drain_calm;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic c, input logic p,
                           input logic [TIME_W-1:0] b, input logic [TIME_W-1:0] g);
    pending_req.push_back('{c, p, b, g});
    n_queued++;
  endtask

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // one debounced decision worth of ticks, sometimes after a short glitch;
  // pin is active low, so a down decision drives zeros
  task automatic push_decision(input logic down);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) push_word(CMD_TICK, down, any_time(), any_time());
    end
    repeat (RUN_NEEDED) push_word(CMD_TICK, ~down, any_time(), any_time());
  endtask

  // sender holds off until every owed result word is back
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_res.size() != 0) @(posedge clk);
  endtask

  // one phase: drain all owed results, write timeout_extra, then random confirmations
  task automatic run_phase(input logic [TIME_W-1:0] extra, input int n_items);
    int                made0;
    int                r;
    int                style;
    int                holds;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] goal;
    wait_idle();
    repeat (3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= extra;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    extra_q = extra;
    n_cfg++;

    made0 = n_queued;
    while (n_queued - made0 < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // noise: loose ticks and starts with random fields
        repeat ($urandom_range(1, 8)) begin
          push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    any_time(), any_time());
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5)       base = '0;
        else if (r < 75) base = TIME_W'($urandom_range(1, 12));
        else if (r < 92) base = TIME_W'($urandom_range(13, 400));
        else             base = any_time();
        r = $urandom_range(0, 99);
        if (r < 60)      goal = TIME_W'($urandom_range(0, 5));
        else if (r < 90) goal = TIME_W'($urandom_range(6, 20));
        else             goal = any_time();
        push_word(CMD_START, 1'($urandom_range(0, 1)), base, goal);
        // presses left over from before, then the release
        repeat ($urandom_range(0, 2)) push_decision(1'b1);
        repeat ($urandom_range(1, 2)) push_decision(1'b0);
        holds = (goal > 24) ? int'($urandom_range(0, 24)) : int'(goal);
        style = $urandom_range(0, 99);
        if (style < 70) begin
          repeat (holds) push_decision(1'b1);
        end else if (style < 90) begin
          // let go early
          repeat ($urandom_range(0, holds)) push_decision(1'b1);
          push_decision(1'b0);
        end else begin
          repeat ($urandom_range(0, 6)) push_decision(1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin : main_blk
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_START;
    req_ch.pin_level   = 1'b1;
    req_ch.base_time   = '0;
    req_ch.hold_target = '0;
    res_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed words, reset value of timeout_extra
    push_word(CMD_TICK, 1'b0, '1, '1);            // tick while idle
    push_word(CMD_TICK, 1'b1, '0, '0);
    push_word(CMD_START, 1'b0, '0, '1);           // base time zero, instant success
    push_word(CMD_START, 1'b1, '1, 16'd1);        // widest base time
    push_word(CMD_START, 1'b0, '0, '0);           // start while busy is dropped
    repeat (RUN_NEEDED) push_word(CMD_TICK, 1'b0, '0, '1);  // press before release
    repeat (RUN_NEEDED) push_word(CMD_TICK, 1'b1, '1, '0);  // release
    repeat (RUN_NEEDED) push_word(CMD_TICK, 1'b0, '0, '0);  // hold reaches target
    push_word(CMD_START, 1'b1, 16'd1, '0);        // zero target
    repeat (RUN_NEEDED) push_word(CMD_TICK, 1'b1, '1, '1);  // first release succeeds

    run_phase(16'd0, 230);
    run_phase(16'hFFFF, 230);
    run_phase(16'd1, 230);
    run_phase(16'd3, 230);
    run_phase(any_time(), 230);
    run_phase(TIMEOUT_EXTRA_RESET, 230);
    run_phase(TIME_W'($urandom_range(0, 10)), 230);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("covered %0d request words and %0d result words:",
             n_accepted, n_results);
    $display("  %0d requests, %0d successes, %0d failures",
             n_request, n_success, n_failure);
    $display("timeout_extra written %0d times, from 0 up to 65535", n_cfg);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog_blk
    #(RUN_LIMIT_NS);
    $display("run did not finish in time, %0d of %0d words accepted", n_accepted, n_queued);
    $display("status: fail");
    $finish;
  end

endmodule
